// ===== hw/rtl/nbm_pkg.sv =====
`timescale 1ns / 1ps

package nbm_pkg;

  localparam int MaxMatches = 6;
  localparam int MaxBlobs   = 256;
  localparam int CoordBits  = 16;

  // fixed field widths of the ports
  localparam int FieldW = 16;
  localparam int DistW  = 33;
  localparam int IdxW   = 8;
  localparam int CfgIdxW = 2;

  localparam int CoordW = (CoordBits < FieldW) ? CoordBits : FieldW;
  localparam int CntW   = $clog2(MaxBlobs + 1);
  localparam int FillW  = $clog2(MaxMatches + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_CAND   = 2'd1,
    OP_DELETE = 2'd2,
    OP_IDLE   = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TRACKED_X     = 2'd0,
    CFG_TRACKED_Y     = 2'd1,
    CFG_TRACKED_VALID = 2'd2,
    CFG_MAX_DIST      = 2'd3
  } cfg_idx_e;

endpackage

// ===== hw/rtl/nearest_blob_top_k_matcher.sv =====
`timescale 1ns / 1ps

// Keeps up to six candidates sorted by squared distance from the tracked point.
// An item is taken in every cycle (busy_o stays low) and each item gives exactly
// one result at the end of the pipeline, marked by done_o for one cycle: the
// pipeline is an input register, a stage with the two 16x16 squarers and their
// sum, and the list update with its six distance comparators. Results cannot be
// held off, so the receiver must take every done_o cycle. The list registers are
// updated in the last stage, so back-to-back items see each other's effect.
// Configuration writes are always ready and must only be made while no item is
// in flight.
module nearest_blob_top_k_matcher import nbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          op_i,
  input  logic [FieldW-1:0]   blob_x_i,
  input  logic [FieldW-1:0]   blob_y_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [DistW-1:0]    cfg_data_i,
  output logic                done_o,
  output logic                has_match_o,
  output logic signed [8:0]   first_index_o,
  output logic [DistW-1:0]    first_distance_o,
  output logic [2:0]          match_count_o,
  output logic                dropped_o
);

  logic                accept;

  // configuration
  logic [CoordW-1:0]   trk_x_q, trk_y_q;
  logic                trk_valid_q;
  logic [DistW-1:0]    max_dist_q;

  // candidate numbering
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                cnt_full;

  // stage 1
  logic                s1_valid_q;
  op_e                 s1_op_q;
  logic [CoordW-1:0]   s1_x_q, s1_y_q;
  logic [IdxW-1:0]     s1_num_q;
  logic                s1_first_q, s1_drop_q;

  // stage 2
  logic                s2_valid_q;
  op_e                 s2_op_q;
  logic [IdxW-1:0]     s2_num_q;
  logic                s2_first_q, s2_drop_q;
  logic [DistW-1:0]    s2_dist_q, s2_dist_d;
  logic [CoordW-1:0]   dx, dy;
  logic [2*CoordW-1:0] sq_x, sq_y;

  // sorted list
  logic [IdxW-1:0]     lst_idx_q [MaxMatches];
  logic [IdxW-1:0]     lst_idx_d [MaxMatches];
  logic [DistW-1:0]    lst_dist_q [MaxMatches];
  logic [DistW-1:0]    lst_dist_d [MaxMatches];
  logic [FillW-1:0]    fill_q, fill_d;
  logic [MaxMatches-1:0] after;
  logic                keep, ins_en;

  logic                done_q, drop_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_x_q     <= '0;
      trk_y_q     <= '0;
      trk_valid_q <= 1'b0;
      max_dist_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TRACKED_X:     trk_x_q     <= cfg_data_i[CoordW-1:0];
        CFG_TRACKED_Y:     trk_y_q     <= cfg_data_i[CoordW-1:0];
        CFG_TRACKED_VALID: trk_valid_q <= cfg_data_i[0];
        CFG_MAX_DIST:      max_dist_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // numbering runs at the input, so it stays in item order
  assign cnt_full = (cnt_q >= CntW'(MaxBlobs));

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      case (op_e'(op_i))
        OP_CLEAR: cnt_d = '0;
        OP_CAND:  if (!cnt_full) cnt_d = cnt_q + CntW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      done_q     <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= op_e'(op_i);
      s1_x_q     <= blob_x_i[CoordW-1:0];
      s1_y_q     <= blob_y_i[CoordW-1:0];
      s1_num_q   <= IdxW'(cnt_q);
      s1_first_q <= (cnt_q == '0);
      s1_drop_q  <= (op_e'(op_i) == OP_CAND) && cnt_full;
    end
  end

  // squared distance, exact
  assign dx   = (s1_x_q >= trk_x_q) ? (s1_x_q - trk_x_q) : (trk_x_q - s1_x_q);
  assign dy   = (s1_y_q >= trk_y_q) ? (s1_y_q - trk_y_q) : (trk_y_q - s1_y_q);
  assign sq_x = dx * dx;
  assign sq_y = dy * dy;
  assign s2_dist_d = DistW'(sq_x) + DistW'(sq_y);

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_op_q    <= s1_op_q;
      s2_num_q   <= s1_num_q;
      s2_first_q <= s1_first_q;
      s2_drop_q  <= s1_drop_q;
      s2_dist_q  <= s2_dist_d;
    end
  end

  // after[i]: slot i lies at or behind the insert point (ties go behind)
  always_comb begin
    for (int i = 0; i < MaxMatches; i++) begin
      after[i] = (FillW'(i) >= fill_q) || (s2_dist_q < lst_dist_q[i]);
    end
  end

  assign keep   = trk_valid_q && (s2_op_q == OP_CAND) && !s2_drop_q &&
                  (s2_first_q || (s2_dist_q <= max_dist_q));
  assign ins_en = keep && after[MaxMatches-1];

  always_comb begin
    lst_idx_d  = lst_idx_q;
    lst_dist_d = lst_dist_q;
    fill_d     = fill_q;
    if (s2_valid_q) begin
      case (s2_op_q)
        OP_CLEAR: fill_d = '0;
        OP_CAND: begin
          if (ins_en) begin
            if (after[0]) begin
              lst_idx_d[0]  = s2_num_q;
              lst_dist_d[0] = s2_dist_q;
            end
            for (int i = 1; i < MaxMatches; i++) begin
              if (after[i]) begin
                if (after[i-1]) begin
                  lst_idx_d[i]  = lst_idx_q[i-1];
                  lst_dist_d[i] = lst_dist_q[i-1];
                end else begin
                  lst_idx_d[i]  = s2_num_q;
                  lst_dist_d[i] = s2_dist_q;
                end
              end
            end
            if (fill_q < FillW'(MaxMatches)) fill_d = fill_q + FillW'(1);
          end
        end
        OP_DELETE: begin
          if (fill_q != '0) begin
            for (int i = 0; i < MaxMatches - 1; i++) begin
              lst_idx_d[i]  = lst_idx_q[i+1];
              lst_dist_d[i] = lst_dist_q[i+1];
            end
            fill_d = fill_q - FillW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lst_idx_q  <= lst_idx_d;
    lst_dist_q <= lst_dist_d;
    if (s2_valid_q) drop_q <= s2_drop_q;
  end

  assign done_o           = done_q;
  assign dropped_o        = drop_q;
  assign has_match_o      = (fill_q != '0);
  assign match_count_o    = 3'(fill_q);
  assign first_index_o    = has_match_o ? $signed({1'b0, lst_idx_q[0]}) : '1;
  assign first_distance_o = has_match_o ? lst_dist_q[0] : '1;

endmodule

// ===== tb/nearest_blob_top_k_matcher_tb.sv =====
`timescale 1ns / 1ps

module nearest_blob_top_k_matcher_tb;
  import nbm_pkg::*;

  localparam int PipeLat   = 3;
  localparam int StallMax  = 2000;
  localparam logic [DistW-1:0] DistOnes = {DistW{1'b1}};

  typedef struct packed {
    logic [1:0]        op;
    logic [FieldW-1:0] x;
    logic [FieldW-1:0] y;
  } blob_item_t;

  typedef struct {
    logic              has_match;
    logic signed [8:0] first_index;
    logic [DistW-1:0]  first_distance;
    logic [2:0]        match_count;
    logic              dropped;
  } match_status_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [1:0]        op_i = OP_IDLE;
  logic [FieldW-1:0] blob_x_i = '0;
  logic [FieldW-1:0] blob_y_i = '0;
  logic              cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_TRACKED_X;
  logic [DistW-1:0]  cfg_data_i = '0;
  logic              busy_o;
  logic              cfg_ready_o;
  logic              done_o;
  logic              has_match_o;
  logic signed [8:0] first_index_o;
  logic [DistW-1:0]  first_distance_o;
  logic [2:0]        match_count_o;
  logic              dropped_o;

  nearest_blob_top_k_matcher dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .op_i,
    .blob_x_i,
    .blob_y_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .done_o,
    .has_match_o,
    .first_index_o,
    .first_distance_o,
    .match_count_o,
    .dropped_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor copy of registers and list
  logic [FieldW-1:0] trk_x = '0;
  logic [FieldW-1:0] trk_y = '0;
  logic              trk_valid = 1'b0;
  logic [DistW-1:0]  trk_max_d2 = '0;
  logic [IdxW-1:0]   list_num [MaxMatches];
  logic [DistW-1:0]  list_d2 [MaxMatches];
  int                list_fill = 0;
  int                next_num = 0;

  blob_item_t        item_q[$];
  match_status_t     expected_status_q[$];
  match_status_t     want_status;

  int  errors = 0;
  int  n_items = 0;
  int  n_results = 0;
  int  n_cfg = 0;
  int  n_dropped = 0;
  int  n_full = 0;
  int  n_phases = 0;
  int  gap_pct = 0;
  int  gap_left = 0;
  bit  no_gaps = 1'b0;
  int  stall_cnt = 0;

  task automatic flag_mismatch(input string field, input logic [DistW-1:0] got,
                               input logic [DistW-1:0] want);
    $display("mismatch in %s at result %0d: got %0h, want %0h",
             field, n_results, got, want);
    errors++;
  endtask

  // advance the list by one item and queue the status it should report
  task automatic update_match_list(input logic [1:0] op, input logic [FieldW-1:0] bx,
                                   input logic [FieldW-1:0] by);
    match_status_t st;
    logic [DistW-1:0] dx;
    logic [DistW-1:0] dy;
    logic [DistW-1:0] d2;
    int num;
    int pos;
    int k;
    st.dropped = 1'b0;
    case (op)
      OP_CLEAR: begin
        list_fill = 0;
        next_num = 0;
      end
      OP_CAND: begin
        if (next_num >= MaxBlobs) begin
          st.dropped = 1'b1;
        end else begin
          dx = (bx >= trk_x) ? DistW'(bx - trk_x) : DistW'(trk_x - bx);
          dy = (by >= trk_y) ? DistW'(by - trk_y) : DistW'(trk_y - by);
          d2 = dx * dx + dy * dy;
          num = next_num;
          next_num++;
          if (trk_valid && (num == 0 || d2 <= trk_max_d2)) begin
            pos = 0;
            while (pos < list_fill && d2 >= list_d2[pos]) pos++;
            if (!(pos >= list_fill && list_fill >= MaxMatches)) begin
              k = (list_fill < MaxMatches) ? list_fill : MaxMatches - 1;
              while (k > pos) begin
                list_num[k] = list_num[k-1];
                list_d2[k] = list_d2[k-1];
                k--;
              end
              list_num[pos] = IdxW'(num);
              list_d2[pos] = d2;
              if (list_fill < MaxMatches) list_fill++;
            end
          end
        end
      end
      OP_DELETE: begin
        if (list_fill > 0) begin
          for (k = 1; k < list_fill; k++) begin
            list_num[k-1] = list_num[k];
            list_d2[k-1] = list_d2[k];
          end
          list_fill--;
        end
      end
      default: ;
    endcase
    st.has_match      = (list_fill > 0);
    st.first_index    = (list_fill > 0) ? $signed({1'b0, list_num[0]}) : -9'sd1;
    st.first_distance = (list_fill > 0) ? list_d2[0] : DistOnes;
    st.match_count    = 3'(list_fill);
    expected_status_q.insert(expected_status_q.size(), st);
  endtask

  // driver: one transfer per accepted start, random idle bursts in between
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        update_match_list(op_i, blob_x_i, blob_y_i);
        n_items++;
      end
      if (!start_i || !busy_o) begin
        if (gap_left != 0 && !no_gaps) begin
          gap_left <= gap_left - 1;
          start_i <= 1'b0;
        end else if (item_q.size() != 0 && !no_gaps && $urandom_range(0, 99) < gap_pct) begin
          gap_left <= $urandom_range(0, 11);
          start_i <= 1'b0;
        end else if (item_q.size() != 0) begin
          op_i <= item_q[0].op;
          blob_x_i <= item_q[0].x;
          blob_y_i <= item_q[0].y;
          item_q.delete(0);
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // results cannot be held off: check every done_o cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      n_results++;
      if (expected_status_q.size() == 0) begin
        flag_mismatch("result with nothing outstanding", '0, '0);
      end else begin
        want_status = expected_status_q[0];
        expected_status_q.delete(0);
        if (dropped_o) n_dropped++;
        if (match_count_o == 3'(MaxMatches)) n_full++;
        if (has_match_o !== want_status.has_match)
          flag_mismatch("has_match", DistW'(has_match_o), DistW'(want_status.has_match));
        if (first_index_o !== want_status.first_index)
          flag_mismatch("first_index", {24'b0, first_index_o},
                        {24'b0, want_status.first_index});
        if (first_distance_o !== want_status.first_distance)
          flag_mismatch("first_distance", first_distance_o, want_status.first_distance);
        if (match_count_o !== want_status.match_count)
          flag_mismatch("match_count", DistW'(match_count_o),
                        DistW'(want_status.match_count));
        if (dropped_o !== want_status.dropped)
          flag_mismatch("dropped", DistW'(dropped_o), DistW'(want_status.dropped));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallMax) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               stall_cnt, expected_status_q.size());
      $display("nearest_blob_top_k_matcher_tb NOT OK");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [DistW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_TRACKED_X:     trk_x = data[FieldW-1:0];
      CFG_TRACKED_Y:     trk_y = data[FieldW-1:0];
      CFG_TRACKED_VALID: trk_valid = data[0];
      CFG_MAX_DIST:      trk_max_d2 = data;
      default: ;
    endcase
    n_cfg++;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_tracking(input logic [FieldW-1:0] x, input logic [FieldW-1:0] y,
                              input logic v, input logic [DistW-1:0] max_d2);
    write_reg(CFG_TRACKED_X, DistW'(x));
    write_reg(CFG_TRACKED_Y, DistW'(y));
    write_reg(CFG_TRACKED_VALID, DistW'(v));
    write_reg(CFG_MAX_DIST, max_d2);
    n_phases++;
  endtask

  task automatic wait_idle();
    while (item_q.size() != 0 || start_i || expected_status_q.size() != 0)
      @(posedge clk_i);
    repeat (PipeLat + 3) @(posedge clk_i);
  endtask

  function automatic void push_item(input logic [1:0] op, input int x, input int y);
    blob_item_t it;
    it.op = op;
    it.x = FieldW'(x);
    it.y = FieldW'(y);
    item_q.insert(item_q.size(), it);
  endfunction

  // a track run: mostly candidates around the tracked point, some noise
  task automatic push_track_run(input int n, input int spread, input bit lead_clear,
                                input bit allow_clear);
    int i;
    int r;
    int x;
    int y;
    int px;
    int py;
    px = trk_x;
    py = trk_y;
    if (lead_clear) push_item(OP_CLEAR, $urandom(), $urandom());
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_item(OP_DELETE, $urandom(), $urandom());
      end else if (r < 12) begin
        push_item(OP_IDLE, $urandom(), $urandom());
      end else if (r < 14 && allow_clear) begin
        push_item(OP_CLEAR, $urandom(), $urandom());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          x = px;
          y = py;
        end else if (r < 18) begin
          x = $urandom_range(0, 1) ? 65535 : 0;
          y = $urandom_range(0, 1) ? 65535 : 0;
        end else if (r < 30) begin
          x = $urandom_range(0, 65535);
          y = $urandom_range(0, 65535);
        end else begin
          x = int'(trk_x) + $urandom_range(0, 2 * spread) - spread;
          y = int'(trk_y) + $urandom_range(0, 2 * spread) - spread;
        end
        push_item(OP_CAND, x, y);
        px = x;
        py = y;
      end
    end
  endtask

  initial begin
    int ph;
    int spread;
    int count;
    int tx;
    int ty;
    logic [DistW-1:0] max_d2;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, first candidate, threshold, ties, trimming
    gap_pct = 20;
    tx = 1600;
    ty = 800;
    set_tracking(FieldW'(tx), FieldW'(ty), 1'b1, DistW'(10000));
    push_item(OP_IDLE, 0, 0);
    push_item(OP_DELETE, 65535, 65535);
    push_item(OP_CLEAR, 0, 0);
    push_item(OP_CAND, tx, ty);
    push_item(OP_CAND, 65535, 65535);
    push_item(OP_CAND, 0, 0);
    push_item(OP_CAND, tx + 16, ty);
    push_item(OP_CAND, tx, ty + 16);
    push_item(OP_CAND, tx + 8, ty);
    push_item(OP_CAND, tx + 32, ty + 32);
    push_item(OP_CAND, tx + 4, ty + 4);
    push_item(OP_CAND, tx + 48, ty);
    push_item(OP_CAND, tx + 64, ty + 64);
    push_item(OP_CAND, tx + 1, ty);
    push_item(OP_DELETE, 0, 0);
    push_item(OP_DELETE, 0, 0);
    push_item(OP_IDLE, 65535, 65535);
    push_item(OP_CLEAR, 65535, 65535);
    push_item(OP_CAND, 65535, 0);
    push_item(OP_CAND, 0, 65535);
    push_item(OP_DELETE, 0, 0);
    push_item(OP_DELETE, 0, 0);
    push_item(OP_CAND, tx, ty - 1);
    wait_idle();

    for (ph = 0; ph < 10; ph++) begin
      spread = 16 << $urandom_range(0, 6);
      tx = $urandom_range(0, 65535);
      ty = $urandom_range(0, 65535);
      max_d2 = DistW'($urandom_range(0, 2 * spread * spread));
      case (ph)
        0: set_tracking('0, '0, 1'b1, DistOnes);
        1: set_tracking('1, '1, 1'b1, '0);
        // track lost: new candidates are not taken into the list
        2: set_tracking(FieldW'(tx), FieldW'(ty), 1'b0, max_d2);
        5: set_tracking(FieldW'(tx), FieldW'(ty), 1'b1, DistW'(64'h1_FFFC_0002));
        6: set_tracking(FieldW'(tx), FieldW'(ty), 1'b1,
                        {1'($urandom_range(0, 1)), 32'($urandom())});
        default: set_tracking(FieldW'(tx), FieldW'(ty), 1'b1, max_d2);
      endcase
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 50;
      endcase
      no_gaps = (ph == 9);
      if (ph == 4) begin
        // run numbering past its end with no clear in between
        push_track_run(320, spread, 1'b1, 1'b0);
      end else begin
        count = 0;
        while (count < 100) begin
          push_track_run($urandom_range(3, 24), spread, $urandom_range(0, 9) != 0, 1'b1);
          count = count + item_q.size() - count;
        end
      end
      wait_idle();
    end

    repeat (PipeLat + 5) @(posedge clk_i);
    $display("covered %0d items under %0d register settings (%0d writes), %0d results",
             n_items, n_phases, n_cfg, n_results);
    $display("dropped candidates seen: %0d, full-list results seen: %0d",
             n_dropped, n_full);
    if (errors == 0) begin
      $display("nearest_blob_top_k_matcher_tb OK");
    end else begin
      $display("nearest_blob_top_k_matcher_tb NOT OK");
    end
    $finish;
  end

endmodule
